@@ hw/rtl/ssba_pkg.sv @@
package ssba_pkg;

  // Sizing of the slot map
  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_SLOT = 8;
  localparam int SLOT_W           = 10;
  localparam int SECTOR_W         = 13;
  localparam int COUNT_W          = 11;
  localparam int CNT_W            = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;

  // Map memory organization: one row holds the used bits of WORD_W slots
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = MAX_SLOTS / WORD_W;
  localparam int ROW_W  = SLOT_W - BIT_W;

  // Register map
  localparam int PADDR_W = 3;
  localparam logic REG_SLOT_COUNT = 1'b0;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_LOAD  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Request handed from the lookup logic to the sector burst generator
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              is_write;
    logic              single;
  } burst_cmd_t;

  typedef struct packed {
    logic found;
    logic [BIT_W-1:0] idx;
  } first_set_t;

  // Lowest set bit of a map row
  function automatic first_set_t first_set(input logic [WORD_W-1:0] vec);
    first_set_t r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/swap_slot_bitmap_allocator_unit.sv @@
// First-fit swap slot allocator. The used bit of each slot lives in a 32 x 32-bit
// map memory with per-row valid bits and a per-row full mark, so reset takes effect
// at once with no clearing pass. A request is accepted when the block is idle, is
// looked up in the cycle after (the map memory read), and its result run is handed
// to the burst generator; the next request is accepted while that run drains. A
// successful store or load produces eight sector results, and a failed request
// produces one result; each request passes through accept and then lookup, and the
// lookup waits while the burst generator is still busy with the previous run.
// slot_count is at address 0 and saturates to 1024 usable slots.
module swap_slot_bitmap_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssba_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [ssba_pkg::SLOT_W-1:0]   slot_index,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [ssba_pkg::SLOT_W-1:0]   slot,
  output logic [ssba_pkg::SECTOR_W-1:0] sector,
  output logic                          is_write,
  output logic                          last
);

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t                        state;
  logic [ssba_pkg::COUNT_W-1:0]  slot_count;
  logic [ssba_pkg::COUNT_W-1:0]  limit;
  logic [ssba_pkg::ROWS-1:0]     row_valid;
  logic [ssba_pkg::ROWS-1:0]     row_full;
  logic [ssba_pkg::ROWS-1:0]     eligible;
  ssba_pkg::first_set_t          row_pick;
  ssba_pkg::first_set_t          bit_pick;

  logic                          op_q;
  logic [ssba_pkg::SLOT_W-1:0]   idx_q;
  logic [ssba_pkg::ROW_W-1:0]    row_q;
  logic                          row_found_q;

  logic                          accept;
  logic [ssba_pkg::ROW_W-1:0]    rd_row;
  logic [ssba_pkg::WORD_W-1:0]   rd_data;
  logic [ssba_pkg::WORD_W-1:0]   word;
  logic [ssba_pkg::WORD_W-1:0]   new_word;
  logic [ssba_pkg::SLOT_W-1:0]   alloc_slot;
  logic                          ok;
  logic                          wr_en;

  logic                          cmd_valid;
  logic                          cmd_ready;
  ssba_pkg::burst_cmd_t          cmd;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ssba_pkg::REG_SLOT_COUNT)
                ? {{(32 - ssba_pkg::COUNT_W){1'b0}}, slot_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= ssba_pkg::COUNT_W'(ssba_pkg::MAX_SLOTS);
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == ssba_pkg::REG_SLOT_COUNT) begin
      slot_count <= pwdata[ssba_pkg::COUNT_W-1:0];
    end
  end

  // Saturate the usable slot count
  assign limit = (slot_count > ssba_pkg::COUNT_W'(ssba_pkg::MAX_SLOTS))
               ? ssba_pkg::COUNT_W'(ssba_pkg::MAX_SLOTS) : slot_count;

  // Pick the lowest row that starts below the limit and still has a free slot
  always_comb begin
    for (int r = 0; r < ssba_pkg::ROWS; r++) begin
      eligible[r] = (ssba_pkg::COUNT_W'(r * ssba_pkg::WORD_W) < limit) && !row_full[r];
    end
  end
  assign row_pick = ssba_pkg::first_set(eligible);

  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign rd_row = (operation == ssba_pkg::OP_LOAD)
                ? slot_index[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_W]
                : row_pick.idx[ssba_pkg::ROW_W-1:0];

  ssba_map_ram u_map (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_row),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (row_q),
    .wr_data (new_word)
  );

  // Decide the request from the row just read
  always_comb begin
    word       = row_valid[row_q] ? rd_data : '0;
    bit_pick   = ssba_pkg::first_set(~word);
    alloc_slot = {row_q, bit_pick.idx};
    if (op_q == ssba_pkg::OP_STORE) begin
      ok       = row_found_q && bit_pick.found
                 && ({1'b0, alloc_slot} < limit);
      new_word = word | (ssba_pkg::WORD_W'(1) << bit_pick.idx);
      cmd.status   = ok ? ssba_pkg::ST_OK : ssba_pkg::ST_FULL;
      cmd.slot     = ok ? alloc_slot : '0;
      cmd.is_write = 1'b1;
    end else begin
      ok       = ({1'b0, idx_q} < limit) && word[idx_q[ssba_pkg::BIT_W-1:0]];
      new_word = word & ~(ssba_pkg::WORD_W'(1) << idx_q[ssba_pkg::BIT_W-1:0]);
      cmd.status   = ok ? ssba_pkg::ST_OK : ssba_pkg::ST_BAD;
      cmd.slot     = idx_q;
      cmd.is_write = 1'b0;
    end
    cmd.single = !ok;
  end

  assign cmd_valid = (state == S_LOOKUP);
  assign wr_en     = cmd_valid && cmd_ready && ok;

  // Request sequencing and captured request fields
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (cmd_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (accept) begin
      op_q        <= operation;
      idx_q       <= slot_index;
      row_q       <= rd_row;
      row_found_q <= (operation == ssba_pkg::OP_LOAD) || row_pick.found;
    end
  end

  // Row valid and full marks follow every write back
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
    end else if (wr_en) begin
      row_valid[row_q] <= 1'b1;
      row_full[row_q]  <= &new_word;
    end
  end

  ssba_burst_gen u_burst (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .slot      (slot),
    .sector    (sector),
    .is_write  (is_write),
    .last      (last)
  );

  // A failure produces a single result
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ssba_pkg::ST_OK |-> last)
    else $error("failure result not marked last");

  // The final sector of a run belongs to its slot
  a_last_sector: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ssba_pkg::ST_OK && last
    |-> sector == ssba_pkg::SECTOR_W'(slot * ssba_pkg::SECTORS_PER_SLOT
                                      + ssba_pkg::SECTORS_PER_SLOT - 1))
    else $error("last sector does not match slot");

  // A written row is valid afterwards
  a_row_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> row_valid[$past(row_q)])
    else $error("written row not marked valid");

  // No new request is taken while a lookup waits for the burst generator
  a_no_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> !$past(accept) && state == S_LOOKUP)
    else $error("lookup abandoned before hand-off");

endmodule

@@ hw/rtl/ssba_map_ram.sv @@
module ssba_map_ram (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [ssba_pkg::ROW_W-1:0]  rd_addr,
  output logic [ssba_pkg::WORD_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [ssba_pkg::ROW_W-1:0]  wr_addr,
  input  logic [ssba_pkg::WORD_W-1:0] wr_data
);

  logic [ssba_pkg::WORD_W-1:0] mem [ssba_pkg::ROWS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/ssba_burst_gen.sv @@
module ssba_burst_gen (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  ssba_pkg::burst_cmd_t          cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [ssba_pkg::SLOT_W-1:0]   slot,
  output logic [ssba_pkg::SECTOR_W-1:0] sector,
  output logic                          is_write,
  output logic                          last
);

  logic                       busy;
  logic [ssba_pkg::CNT_W-1:0] cnt;
  logic                       take;
  logic                       beat;

  assign beat      = busy && out_ready;
  assign cmd_ready = !busy || (out_ready && last);
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = busy;

  // Track an active run of results
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (beat && last) begin
      busy <= 1'b0;
    end
  end

  // Load a new run, or advance to the next sector
  always_ff @(posedge clk) begin
    if (take) begin
      status   <= cmd.status;
      slot     <= cmd.slot;
      is_write <= cmd.is_write;
      cnt      <= '0;
      sector   <= cmd.single ? '0
                 : ssba_pkg::SECTOR_W'(cmd.slot * ssba_pkg::SECTORS_PER_SLOT);
      last     <= cmd.single || (ssba_pkg::SECTORS_PER_SLOT == 1);
    end else if (beat) begin
      cnt    <= cnt + 1'b1;
      sector <= sector + 1'b1;
      last   <= (cnt == ssba_pkg::CNT_W'(ssba_pkg::SECTORS_PER_SLOT - 2));
    end
  end

endmodule

@@ bench/tb.sv @@
module tb;

  typedef struct packed {
    ssba_pkg::status_t             status;
    logic [ssba_pkg::SLOT_W-1:0]   slot;
    logic [ssba_pkg::SECTOR_W-1:0] sector;
    logic                          is_write;
    logic                          last;
  } sector_result_t;

  localparam logic [ssba_pkg::PADDR_W-1:0] SLOT_COUNT_ADDR =
    ssba_pkg::PADDR_W'(4 * int'(ssba_pkg::REG_SLOT_COUNT));
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ssba_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  logic                          operation;
  logic [ssba_pkg::SLOT_W-1:0]   slot_index;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    status;
  logic [ssba_pkg::SLOT_W-1:0]   slot;
  logic [ssba_pkg::SECTOR_W-1:0] sector;
  logic                          is_write;
  logic                          last;

  // Shadow of the block: used bits and the slot count register
  bit                            shadow_used[ssba_pkg::MAX_SLOTS];
  logic [ssba_pkg::COUNT_W-1:0]  shadow_count;
  sector_result_t                pending_sectors[$];

  int idle_pct;
  int hold_cycles;
  int cycle_count;
  int error_count;
  int results_seen;
  int stores_sent;
  int loads_sent;
  int served_runs;
  int full_fails;
  int bad_loads;

  swap_slot_bitmap_allocator_unit uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot       (slot),
    .sector     (sector),
    .is_write   (is_write),
    .last       (last)
  );

  // Generate the clock
  always #4 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Drive the result ready: long hold-off when asked, random idling otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  function automatic sector_result_t make_result(ssba_pkg::status_t st,
                                                 logic [ssba_pkg::SLOT_W-1:0] s,
                                                 logic [ssba_pkg::SECTOR_W-1:0] sec,
                                                 logic wr, logic lst);
    sector_result_t r;
    r.status   = st;
    r.slot     = s;
    r.sector   = sec;
    r.is_write = wr;
    r.last     = lst;
    return r;
  endfunction

  function automatic int usable_slots();
    return (int'(shadow_count) > ssba_pkg::MAX_SLOTS) ? ssba_pkg::MAX_SLOTS
                                                       : int'(shadow_count);
  endfunction

  function automatic int free_below_limit();
    int n;
    n = 0;
    for (int s = 0; s < usable_slots(); s++) if (!shadow_used[s]) n++;
    return n;
  endfunction

  // Pick a used slot at random, optionally only one below the usable count; -1 if none
  function automatic int pick_used_slot(bit in_range_only);
    int cand[$];
    for (int s = 0; s < ssba_pkg::MAX_SLOTS; s++)
      if (shadow_used[s] && (!in_range_only || s < usable_slots())) cand.push_back(s);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // Queue the eight sector transactions of one slot
  task automatic push_sector_run(int s, logic wr);
    for (int k = 0; k < ssba_pkg::SECTORS_PER_SLOT; k++)
      pending_sectors.push_back(make_result(ssba_pkg::ST_OK, ssba_pkg::SLOT_W'(s),
                                  ssba_pkg::SECTOR_W'(s * ssba_pkg::SECTORS_PER_SLOT + k),
                                  wr, k == ssba_pkg::SECTORS_PER_SLOT - 1));
  endtask

  // First-fit allocation and load/free against the shadow map
  task automatic predict_request(ssba_pkg::op_t op, logic [ssba_pkg::SLOT_W-1:0] idx);
    int limit;
    int hit;
    limit = usable_slots();
    hit = -1;
    if (op == ssba_pkg::OP_STORE) begin
      for (int s = 0; s < limit; s++) begin
        if (hit < 0 && !shadow_used[s]) hit = s;
      end
      if (hit >= 0) begin
        shadow_used[hit] = 1'b1;
        push_sector_run(hit, 1'b1);
        served_runs++;
      end else begin
        pending_sectors.push_back(make_result(ssba_pkg::ST_FULL, '0, '0, 1'b1, 1'b1));
        full_fails++;
      end
    end else if (int'(idx) < limit && shadow_used[idx]) begin
      push_sector_run(int'(idx), 1'b0);
      shadow_used[idx] = 1'b0;
      served_runs++;
    end else begin
      pending_sectors.push_back(make_result(ssba_pkg::ST_BAD, idx, '0, 1'b0, 1'b1));
      bad_loads++;
    end
  endtask

  // Offer one request; hold valid and payload until the transaction is accepted
  task automatic send_request(ssba_pkg::op_t op, logic [ssba_pkg::SLOT_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    if (op == ssba_pkg::OP_STORE) stores_sent++;
    else loads_sent++;
    predict_request(op, idx);
  endtask

  // Drop valid and wait until every expected transaction has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sectors.size() != 0) @(posedge clk);
  endtask

  // Write the slot count through the register port while the block is idle
  task automatic set_slot_count(logic [ssba_pkg::COUNT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOT_COUNT_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_count = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic report_mismatch(string what, sector_result_t want, sector_result_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s at cycle %0d:", what, cycle_count);
      $display("  expected st=%0d slot=%0d sec=%0d wr=%0b last=%0b",
               want.status, want.slot, want.sector, want.is_write, want.last);
      $display("  got      st=%0d slot=%0d sec=%0d wr=%0b last=%0b",
               got.status, got.slot, got.sector, got.is_write, got.last);
    end
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    sector_result_t got;
    sector_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = make_result(ssba_pkg::status_t'(status), slot, sector, is_write, last);
      results_seen++;
      if (pending_sectors.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_sectors.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.sector !== want.sector || got.is_write !== want.is_write ||
            got.last !== want.last)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // Corner cases: first fit, double load, shrunk and saturated counts, full map
  task automatic test_directed();
    send_request(ssba_pkg::OP_STORE, '0);
    send_request(ssba_pkg::OP_STORE, '1);
    send_request(ssba_pkg::OP_LOAD, 10'd0);
    send_request(ssba_pkg::OP_LOAD, 10'd0);
    send_request(ssba_pkg::OP_LOAD, 10'd1023);
    send_request(ssba_pkg::OP_STORE, 10'h155);
    set_slot_count(11'd0);
    send_request(ssba_pkg::OP_STORE, '0);
    send_request(ssba_pkg::OP_LOAD, 10'd1);
    set_slot_count(11'd2047);
    send_request(ssba_pkg::OP_LOAD, 10'd1);
    send_request(ssba_pkg::OP_STORE, 10'h2aa);
    set_slot_count(11'd3);
    send_request(ssba_pkg::OP_STORE, '0);
    send_request(ssba_pkg::OP_STORE, '0);
    send_request(ssba_pkg::OP_LOAD, 10'd2);
    send_request(ssba_pkg::OP_LOAD, 10'd512);
    send_request(ssba_pkg::OP_STORE, '0);
    set_slot_count(11'd1);
    send_request(ssba_pkg::OP_LOAD, 10'd1);
    send_request(ssba_pkg::OP_LOAD, 10'd0);
    send_request(ssba_pkg::OP_STORE, '0);
    send_request(ssba_pkg::OP_STORE, '0);
  endtask

  // Hold the result side off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    set_slot_count(11'd1024);
    @(posedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 12; i++) send_request(ssba_pkg::OP_STORE, 10'($urandom));
    for (int i = 0; i < 4; i++)
      send_request(ssba_pkg::OP_LOAD, ssba_pkg::SLOT_W'(pick_used_slot(1'b1)));
    wait_drained();
  endtask

  // Mostly well-formed traffic (stores and loads of used slots), some noise
  task automatic run_random_phase(logic [ssba_pkg::COUNT_W-1:0] count, int n_items,
                                  int pct);
    int pick;
    set_slot_count(count);
    idle_pct = pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        pick = pick_used_slot(1'b1);
        if (pick < 0 || $urandom_range(0, 1) == 0)
          send_request(ssba_pkg::OP_STORE, 10'($urandom));
        else
          send_request(ssba_pkg::OP_LOAD, ssba_pkg::SLOT_W'(pick));
      end else begin
        pick = pick_used_slot(1'b0);
        if (pick < 0 || $urandom_range(0, 1) == 0)
          send_request(ssba_pkg::op_t'($urandom_range(0, 1)), 10'($urandom));
        else
          send_request(ssba_pkg::OP_LOAD, ssba_pkg::SLOT_W'(pick));
      end
    end
    idle_pct = 20;
  endtask

  task automatic test_random();
    run_random_phase(11'd1024, 35, 20);
    run_random_phase(11'd1, 35, 20);
    run_random_phase(11'd6, 35, 0);
    run_random_phase(11'd33, 35, 20);
    run_random_phase(11'd0, 20, 20);
    run_random_phase(11'd2047, 35, 20);
    run_random_phase(ssba_pkg::COUNT_W'($urandom_range(2, 100)), 30, 20);
    run_random_phase(11'd12, 35, 20);
  endtask

  // Fill every usable slot of a two-row map so no row is left to search
  task automatic test_fill();
    set_slot_count(11'd64);
    while (free_below_limit() > 0) send_request(ssba_pkg::OP_STORE, 10'($urandom));
    send_request(ssba_pkg::OP_STORE, '1);
    send_request(ssba_pkg::OP_LOAD, 10'd63);
    send_request(ssba_pkg::OP_STORE, '0);
    send_request(ssba_pkg::OP_LOAD, 10'd63);
    wait_drained();
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    operation    = 1'b0;
    slot_index   = '0;
    out_ready    = 1'b0;
    idle_pct     = 20;
    hold_cycles  = 0;
    shadow_count = 11'd1024;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random();
    test_fill();

    // Let any stray transaction show up before deciding
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d stores, %0d loads), checked %0d sector transactions.",
             stores_sent + loads_sent, stores_sent, loads_sent, results_seen);
    $display("Served %0d runs, %0d no-free-slot, %0d bad loads; counts 0..2047, full map.",
             served_runs, full_fails, bad_loads);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
